// ----- design/ufst_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ufst_pkg
// Shared types and constants for the union-find spanning-tree wall unit.
// ----------------------------------------------------------------------------
package ufst_pkg;

    // field widths fixed by the interface
    localparam int DIM_W   = 6;    // grid_width / grid_height registers
    localparam int IDX_W   = 10;   // edge_from / edge_to cell indices
    localparam int RC_W    = 5;    // cell_row / cell_col
    localparam int CNT_W   = 10;   // merge counter
    localparam int CELLS_W = 11;   // cell count, up to 1024
    localparam int PROD_W  = 2 * DIM_W;
    localparam int CFG_IDX_W = 1;

    // grid dimension limits
    localparam logic [DIM_W-1:0] DIM_MIN   = 6'd2;
    localparam logic [DIM_W-1:0] DIM_MAX   = 6'd32;
    localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

    // restoring divider steps, one quotient bit per step
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 4'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_COMP,
        ST_COMP_CHK,
        ST_LINK_ROOT,
        ST_LINK_CHILD,
        ST_DONE
    } ufst_state_t;

endpackage
`default_nettype wire

// ----- design/union_find_spanning_tree_walls_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// union_find_spanning_tree_walls_unit
// Kruskal union-find over maze cells, one wall decision per edge word.
//
// usage
//   input channel  : in_valid / in_stall, word = new_maze, edge_from, edge_to
//   output channel : out_valid / out_stall, word = merged, wall_is_down,
//                    cell_row, cell_col, tree_full
//   config channel : cfg_valid / cfg_ready (always ready), cfg_index selects
//                    grid_width (0) or grid_height (1), cfg_data is the value;
//                    write only while no edge is in flight
//   every accepted edge word gives exactly one output word
//   sequence: a check state, then for each endpoint a root walk (one read
//     per hop) and a path compression pass that points every node on the
//     path at the root, then a join when the roots differ; the 10-step
//     row/column divider runs alongside and the word is held in the finish
//     state until the divider is done
//   one edge is in flight at a time; in_stall is high from acceptance until
//     the output word is loaded into the output register
//   reset and new_maze both run a clearing pass over all MAX_NODES entries
//     of the set memory (one entry per cycle) with in_stall high; a new_maze
//     edge is then processed against the fresh sets
//   a stalled output word is held in the output register; the next edge is
//     still accepted and waits in its final state for the register to free
// ----------------------------------------------------------------------------
module union_find_spanning_tree_walls_unit
    import ufst_pkg::*;
#(
    parameter int MAX_NODES = 1024
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    // edge words in
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 new_maze,
    input  wire logic [IDX_W-1:0]     edge_from,
    input  wire logic [IDX_W-1:0]     edge_to,
    // wall decisions out
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      merged,
    output logic                      wall_is_down,
    output logic [RC_W-1:0]           cell_row,
    output logic [RC_W-1:0]           cell_col,
    output logic                      tree_full
);

    // address width, and entry = {root flag, size or parent}
    localparam int AW = $clog2(MAX_NODES);
    localparam int SW = AW + 1;
    localparam int EW = SW + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_NODES - 1);
    localparam logic [EW-1:0] SINGLETON = {1'b1, SW'(1)};

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] grid_width_reg, grid_width_next;
    logic [DIM_W-1:0] grid_height_reg, grid_height_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_next  = cfg_data;
                REG_GRID_HEIGHT: grid_height_next = cfg_data;
            endcase
        end
    end

    // clamped dimensions and cell count
    logic [DIM_W-1:0]   w_c, h_c;
    logic [PROD_W-1:0]  prod;
    logic [CELLS_W-1:0] cells;

    always_comb
    begin
        if (grid_width_reg < DIM_MIN)
            w_c = DIM_MIN;
        else if (grid_width_reg > DIM_MAX)
            w_c = DIM_MAX;
        else
            w_c = grid_width_reg;

        if (grid_height_reg < DIM_MIN)
            h_c = DIM_MIN;
        else if (grid_height_reg > DIM_MAX)
            h_c = DIM_MAX;
        else
            h_c = grid_height_reg;

        prod = PROD_W'(w_c) * PROD_W'(h_c);
        // only a small node capacity ever caps the count
        if (32'(prod) > MAX_NODES)
            cells = CELLS_W'(MAX_NODES);
        else
            cells = CELLS_W'(prod);
    end

    // ------------------------------------------------------------------
    // set memory: single port, registered read
    // ------------------------------------------------------------------
    logic [EW-1:0] set_mem [MAX_NODES];
    logic [EW-1:0] mem_q_reg;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [EW-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            set_mem[mem_addr] <= mem_wdata;
        mem_q_reg <= set_mem[mem_addr];
    end

    // read data fields
    logic          q_root;
    logic [SW-1:0] q_size;
    logic [AW-1:0] q_parent;

    assign q_root   = mem_q_reg[EW-1];
    assign q_size   = mem_q_reg[SW-1:0];
    assign q_parent = mem_q_reg[AW-1:0];

    // ------------------------------------------------------------------
    // sequencer registers
    // ------------------------------------------------------------------
    ufst_state_t      state_reg, state_next;
    logic             pend_reg, pend_next;        // edge waits behind clear pass
    logic [AW-1:0]    clr_idx_reg, clr_idx_next;
    logic [IDX_W-1:0] from_reg, from_next;
    logic [IDX_W-1:0] to_reg, to_next;
    logic [AW-1:0]    cur_reg, cur_next;
    logic             side_reg, side_next;        // 0 finding from, 1 finding to
    logic [AW-1:0]    root_a_reg, root_a_next;
    logic [SW-1:0]    size_a_reg, size_a_next;
    logic [AW-1:0]    root_b_reg, root_b_next;
    logic [SW-1:0]    size_b_reg, size_b_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             merged_reg, merged_next;
    logic             full_reg, full_next;

    // row/column divider
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [IDX_W-1:0]     div_q_reg, div_q_next;  // dividend out, quotient in
    logic [RC_W-1:0]      div_rem_reg, div_rem_next;
    logic [DIM_W-1:0]     div_trial;
    logic                 div_ge;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic             out_merged_reg, out_merged_next;
    logic             out_down_reg, out_down_next;
    logic [RC_W-1:0]  out_row_reg, out_row_next;
    logic [RC_W-1:0]  out_col_reg, out_col_next;
    logic             out_full_reg, out_full_next;

    // helper terms
    logic [AW-1:0] from_addr, to_addr, side_root, side_start;
    logic [AW-1:0] big_root, small_root;
    logic [SW-1:0] size_sum;
    logic          in_take, out_free;

    assign from_addr  = AW'(from_reg);
    assign to_addr    = AW'(to_reg);
    assign side_root  = side_reg ? root_b_reg : root_a_reg;
    assign side_start = side_reg ? to_addr : from_addr;
    // equal sizes put the from root under the to root
    assign big_root   = (size_a_reg > size_b_reg) ? root_a_reg : root_b_reg;
    assign small_root = (size_a_reg > size_b_reg) ? root_b_reg : root_a_reg;
    assign size_sum   = SW'(size_a_reg + size_b_reg);

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign div_trial = {div_rem_reg, div_q_reg[IDX_W-1]};
    assign div_ge    = (div_trial >= w_c);

    always_comb
    begin
        state_next   = state_reg;
        pend_next    = pend_reg;
        clr_idx_next = clr_idx_reg;
        from_next    = from_reg;
        to_next      = to_reg;
        cur_next     = cur_reg;
        side_next    = side_reg;
        root_a_next  = root_a_reg;
        size_a_next  = size_a_reg;
        root_b_next  = root_b_reg;
        size_b_next  = size_b_reg;
        count_next   = count_reg;
        merged_next  = merged_reg;
        full_next    = full_reg;

        div_cnt_next = div_cnt_reg;
        div_q_next   = div_q_reg;
        div_rem_next = div_rem_reg;

        out_valid_next  = out_valid_reg && out_stall;
        out_merged_next = out_merged_reg;
        out_down_next   = out_down_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_full_next   = out_full_reg;

        mem_we    = 1'b0;
        mem_addr  = cur_reg;
        mem_wdata = SINGLETON;

        // divider step, one quotient bit per cycle
        if (div_cnt_reg != '0)
        begin
            div_cnt_next = div_cnt_reg - 1'b1;
            div_q_next   = {div_q_reg[IDX_W-2:0], div_ge};
            div_rem_next = div_ge ? RC_W'(div_trial - w_c) : div_trial[RC_W-1:0];
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_addr     = clr_idx_reg;
                mem_wdata    = SINGLETON;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_ADDR)
                begin
                    clr_idx_next = '0;
                    pend_next    = 1'b0;
                    state_next   = pend_reg ? ST_CHECK : ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_take)
                begin
                    from_next    = edge_from;
                    to_next      = edge_to;
                    merged_next  = 1'b0;
                    full_next    = 1'b0;
                    div_cnt_next = DIV_STEPS;
                    div_q_next   = edge_from;
                    div_rem_next = '0;
                    if (new_maze)
                    begin
                        pend_next  = 1'b1;
                        count_next = '0;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                if ({1'b0, count_reg} >= (cells - 1'b1))
                begin
                    full_next  = 1'b1;
                    state_next = ST_DONE;
                end
                else if ((CELLS_W'(from_reg) >= cells) || (CELLS_W'(to_reg) >= cells))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cur_next   = from_addr;
                    side_next  = 1'b0;
                    state_next = ST_WALK_RD;
                end
            end

            ST_WALK_RD:
            begin
                mem_addr   = cur_reg;
                state_next = ST_WALK_CHK;
            end

            ST_WALK_CHK:
            begin
                if (q_root)
                begin
                    if (side_reg)
                    begin
                        root_b_next = cur_reg;
                        size_b_next = q_size;
                    end
                    else
                    begin
                        root_a_next = cur_reg;
                        size_a_next = q_size;
                    end
                    cur_next   = side_start;
                    state_next = ST_COMP;
                end
                else
                begin
                    // follow the parent, its read is issued right away
                    cur_next = q_parent;
                    mem_addr = q_parent;
                end
            end

            ST_COMP:
            begin
                if (cur_reg == side_root)
                begin
                    if (side_reg)
                    begin
                        state_next = ST_LINK_ROOT;
                    end
                    else
                    begin
                        side_next  = 1'b1;
                        cur_next   = to_addr;
                        state_next = ST_WALK_RD;
                    end
                end
                else
                begin
                    mem_addr   = cur_reg;
                    state_next = ST_COMP_CHK;
                end
            end

            ST_COMP_CHK:
            begin
                if (q_root)
                begin
                    cur_next = side_root;
                end
                else
                begin
                    // point this node straight at the root
                    mem_we    = 1'b1;
                    mem_addr  = cur_reg;
                    mem_wdata = {1'b0, SW'(side_root)};
                    cur_next  = q_parent;
                end
                state_next = ST_COMP;
            end

            ST_LINK_ROOT:
            begin
                if (root_a_reg == root_b_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_addr   = big_root;
                    mem_wdata  = {1'b1, size_sum};
                    state_next = ST_LINK_CHILD;
                end
            end

            ST_LINK_CHILD:
            begin
                mem_we      = 1'b1;
                mem_addr    = small_root;
                mem_wdata   = {1'b0, SW'(big_root)};
                count_next  = count_reg + 1'b1;
                merged_next = 1'b1;
                state_next  = ST_DONE;
            end

            ST_DONE:
            begin
                if ((div_cnt_reg == '0) && out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_merged_next = merged_reg;
                    out_down_next   = ({1'b0, to_reg} != ({1'b0, from_reg} + 1'b1));
                    out_row_next    = div_q_reg[RC_W-1:0];
                    out_col_next    = div_rem_reg;
                    out_full_next   = full_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            pend_reg        <= 1'b0;
            clr_idx_reg     <= '0;
            count_reg       <= '0;
            div_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            grid_width_reg  <= DIM_RESET;
            grid_height_reg <= DIM_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            pend_reg        <= pend_next;
            clr_idx_reg     <= clr_idx_next;
            count_reg       <= count_next;
            div_cnt_reg     <= div_cnt_next;
            out_valid_reg   <= out_valid_next;
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        from_reg       <= from_next;
        to_reg         <= to_next;
        cur_reg        <= cur_next;
        side_reg       <= side_next;
        root_a_reg     <= root_a_next;
        size_a_reg     <= size_a_next;
        root_b_reg     <= root_b_next;
        size_b_reg     <= size_b_next;
        merged_reg     <= merged_next;
        full_reg       <= full_next;
        div_q_reg      <= div_q_next;
        div_rem_reg    <= div_rem_next;
        out_merged_reg <= out_merged_next;
        out_down_reg   <= out_down_next;
        out_row_reg    <= out_row_next;
        out_col_reg    <= out_col_next;
        out_full_reg   <= out_full_next;
    end

    assign out_valid    = out_valid_reg;
    assign merged       = out_merged_reg;
    assign wall_is_down = out_down_reg;
    assign cell_row     = out_row_reg;
    assign cell_col     = out_col_reg;
    assign tree_full    = out_full_reg;

endmodule
`default_nettype wire
